### hdl/rmts_pkg.sv
// ---------------------------------------------------------------------------
// rmts_pkg
// Shared types and constants for the rate-monotonic task scheduler.
// ---------------------------------------------------------------------------
package rmts_pkg;

  localparam int ID_W     = 22;
  localparam int PERIOD_W = 16;
  localparam int BUDGET_W = 16;
  localparam int SHARE_W  = 10;
  localparam int STATUS_W = 3;
  localparam int ACT_W    = 2;

  localparam logic [9:0] PERMILLE      = 10'd1000;
  localparam logic [9:0] BOUND_DEFAULT = 10'd693;

  typedef enum logic [ACT_W-1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_YIELD      = 2'd1,
    ACT_DEREGISTER = 2'd2,
    ACT_TICK       = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RS_SLEEP = 2'd0,
    RS_READY = 2'd1,
    RS_RUN   = 2'd2
  } run_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_APPLY,
    S_DISPATCH,
    S_SUM,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

### hdl/rmts_if.sv
// ---------------------------------------------------------------------------
// rmts_if
// Valid/ready channel carrying one packed payload per beat.
// ---------------------------------------------------------------------------
interface rmts_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/rmts_div.sv
// ---------------------------------------------------------------------------
// rmts_div
// Restoring divider, one quotient bit a cycle: floor(budget*1000/period).
// ---------------------------------------------------------------------------
module rmts_div
  import rmts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [BUDGET_W-1:0] budget,
  input  logic [PERIOD_W-1:0] period,
  output div_ctl_t            ctl,
  output logic [BUDGET_W+9:0] quotient
);

  localparam int NUM_W = BUDGET_W + 10;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]    num;
  logic [PERIOD_W:0]   rem;
  logic [PERIOD_W-1:0] den;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   diff;

  assign trial = {rem[PERIOD_W-1:0], num[NUM_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        num  <= NUM_W'(budget) * NUM_W'(PERMILLE);
        rem  <= '0;
        den  <= period;
      end else if (busy) begin
        if (!diff[PERIOD_W]) begin
          rem <= diff;
          num <= {num[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          num <= {num[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = num;
  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.done |-> $past(busy)) else $error("divider done without busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> (busy || done)) else $error("divider lost state");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");

endmodule

### hdl/rate_monotonic_task_scheduler.sv
// ---------------------------------------------------------------------------
// rate_monotonic_task_scheduler
// Periodic task table with utilization admission and rate-monotonic dispatch.
// ---------------------------------------------------------------------------
// channel  dir  payload
// in       in   action, task_id, task_period, task_budget
// out      out  status, running_valid, running_task, task_slept, used_permille
// apb      in   utilization_bound at byte address 0
//
// Each item runs a lookup scan, an apply step, a dispatch scan and a share
// sum scan; a register that divides (nonzero period) runs the divider first.
// Scans visit one slot a cycle; the divider makes one quotient bit a cycle.
// Reset clears the table valid bits and time. in.ready is low while an item
// is at work or its result waits in the output register.
// ---------------------------------------------------------------------------
module rate_monotonic_task_scheduler
  import rmts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic  clk,
  input  logic  rst,
  rmts_if.sink   in,
  rmts_if.source out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int SUM_W  = SHARE_W + CNT_W + 1;
  localparam int Q_W    = BUDGET_W + 10;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] task_period;
    logic [BUDGET_W-1:0] task_budget;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                running_valid;
    logic [ID_W-1:0]     running_task;
    logic                task_slept;
    logic [SHARE_W-1:0]  used_permille;
  } out_beat_t;

  // configuration
  logic [SHARE_W-1:0] bound;
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {22'd0, bound} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      bound <= BOUND_DEFAULT;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      bound <= pwdata[SHARE_W-1:0];
    end
  end

  // table
  logic [MAX_TASKS-1:0] slot_valid;
  logic [ID_W-1:0]      slot_task    [MAX_TASKS];
  logic [PERIOD_W-1:0]  slot_period  [MAX_TASKS];
  logic [SHARE_W-1:0]   slot_share   [MAX_TASKS];
  run_state_t           slot_state   [MAX_TASKS];
  logic [TIME_BITS-1:0] slot_release [MAX_TASKS];
  logic                 slot_armed   [MAX_TASKS];

  logic [SLOT_W-1:0]    running_slot;
  logic                 running_flag;
  logic [TIME_BITS-1:0] now_ticks;

  fsm_t state, state_next;

  in_beat_t            item;
  logic [CNT_W-1:0]    idx;
  logic [SLOT_W-1:0    ] cur;
  logic                found;
  logic [SLOT_W-1:0]   hit_slot;
  logic                free_ok;
  logic [SLOT_W-1:0]   free_slot;
  logic                sel_ok;
  logic [SLOT_W-1:0]   sel_slot;
  logic [PERIOD_W-1:0] sel_period;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    used_pre;
  logic [STATUS_W-1:0] status;
  logic                slept;
  logic [SHARE_W-1:0]  share;
  out_beat_t           result;
  logic                out_valid;
  logic                div_start;
  div_ctl_t            div_ctl;
  logic [Q_W-1:0]      div_q;
  logic                last;

  assign cur  = idx[SLOT_W-1:0];
  assign last = (idx == CNT_W'(MAX_TASKS - 1));

  rmts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .budget   (item.task_budget),
    .period   (item.task_period),
    .ctl      (div_ctl),
    .quotient (div_q)
  );

  assign in.ready  = (state == S_IDLE) && !out_valid;
  assign out.valid = out_valid;
  assign out.data  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in.valid && in.ready) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last) begin
          state_next = S_APPLY;
          if (item.action == ACT_REGISTER && item.task_period != '0) begin
            state_next = S_DIV;
            div_start  = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_ctl.done) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (last) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic [Q_W:0] total;
  assign total = (Q_W+1)'(used_pre) + (Q_W+1)'(div_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      running_slot <= '0;
      running_flag <= 1'b0;
      now_ticks    <= '0;
      out_valid    <= 1'b0;
      idx          <= '0;
    end else begin
      if (out.valid && out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (in.valid && in.ready) begin
            item     <= in.data;
            found    <= 1'b0;
            free_ok  <= 1'b0;
            sum      <= '0;
            status   <= ST_OK;
            slept    <= 1'b0;
          end
        end
        S_SCAN: begin
          // lookup, first free slot and share total, one slot a cycle
          if (slot_valid[cur]) begin
            sum <= sum + SUM_W'(slot_share[cur]);
            if (slot_task[cur] == item.task_id && !found) begin
              found    <= 1'b1;
              hit_slot <= cur;
            end
          end else if (!free_ok) begin
            free_ok   <= 1'b1;
            free_slot <= cur;
          end
          // tick wakes due tasks against the advanced time
          if (item.action == ACT_TICK && slot_valid[cur] && slot_armed[cur] &&
              slot_state[cur] == RS_SLEEP &&
              slot_release[cur] <= now_ticks + 1'b1) begin
            slot_state[cur]   <= RS_READY;
            slot_armed[cur]   <= 1'b0;
            slot_release[cur] <= slot_release[cur] + TIME_BITS'(slot_period[cur]);
          end
          idx <= last ? '0 : idx + 1'b1;
          if (last) begin
            used_pre <= sum + (slot_valid[cur] ? SUM_W'(slot_share[cur]) : '0);
          end
        end
        S_DIV: ;
        S_APPLY: begin
          idx    <= '0;
          sel_ok <= 1'b0;
          case (item.action)
            ACT_REGISTER: begin
              if (found) begin
                status <= ST_DUPLICATE;
              end else if (!free_ok) begin
                status <= ST_FULL;
              end else if (item.task_period == '0 ||
                           !(total < (Q_W+1)'(bound))) begin
                status <= ST_REFUSED;
              end else begin
                slot_valid[free_slot]   <= 1'b1;
                slot_task[free_slot]    <= item.task_id;
                slot_period[free_slot]  <= item.task_period;
                slot_share[free_slot]   <= div_q[SHARE_W-1:0];
                slot_state[free_slot]   <= RS_SLEEP;
                slot_armed[free_slot]   <= 1'b0;
                slot_release[free_slot] <= now_ticks + TIME_BITS'(item.task_period);
              end
            end
            ACT_YIELD: begin
              if (!found) begin
                status <= ST_NOT_FOUND;
              end else if (now_ticks < slot_release[hit_slot]) begin
                slot_state[hit_slot] <= RS_SLEEP;
                slot_armed[hit_slot] <= 1'b1;
                slept                <= 1'b1;
                if (running_flag && running_slot == hit_slot) begin
                  running_flag <= 1'b0;
                end
              end else begin
                slot_release[hit_slot] <= slot_release[hit_slot] +
                                          TIME_BITS'(slot_period[hit_slot]);
              end
            end
            ACT_DEREGISTER: begin
              if (!found) begin
                status <= ST_NOT_FOUND;
              end else begin
                slot_valid[hit_slot] <= 1'b0;
                slot_armed[hit_slot] <= 1'b0;
                if (running_flag && running_slot == hit_slot) begin
                  running_flag <= 1'b0;
                end
              end
            end
            default: now_ticks <= now_ticks + 1'b1;
          endcase
        end
        S_DISPATCH: begin
          if (slot_valid[cur] && slot_state[cur] == RS_READY &&
              (!sel_ok || slot_period[cur] < sel_period)) begin
            sel_ok     <= 1'b1;
            sel_slot   <= cur;
            sel_period <= slot_period[cur];
          end
          idx <= last ? '0 : idx + 1'b1;
          sum <= '0;
        end
        S_SUM: begin
          if (idx == '0 && sel_ok) begin
            if (!running_flag || slot_period[running_slot] > sel_period) begin
              if (running_flag) begin
                slot_state[running_slot] <= RS_READY;
              end
              slot_state[sel_slot] <= RS_RUN;
              running_slot         <= sel_slot;
              running_flag         <= 1'b1;
            end
          end
          if (slot_valid[cur]) begin
            sum <= sum + SUM_W'(slot_share[cur]);
          end
          idx <= last ? '0 : idx + 1'b1;
        end
        S_DONE: begin
          out_valid              <= 1'b1;
          result.status          <= status;
          result.running_valid   <= running_flag;
          result.running_task    <= running_flag ? slot_task[running_slot] : '0;
          result.task_slept      <= slept;
          result.used_permille   <= sum[SHARE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid) else $error("result dropped");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> state == S_IDLE && !out_valid) else $error("ready while busy");
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out.valid) else $error("no result raised");
  a_run_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && running_flag |-> slot_valid[running_slot])
    else $error("running slot not valid");

endmodule
